/* rtl/nearest_scale_pitch_snap_core_defines.svh */
// Assertion macros for the nearest-scale pitch snap block.
// No dependencies; included by the top level only.
`ifndef NEAREST_SCALE_PITCH_SNAP_CORE_DEFINES_SVH
`define NEAREST_SCALE_PITCH_SNAP_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define NSPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define NSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/nsps_pkg.sv */
// Package for the nearest-scale pitch snap block: sizes, state codes and
// the control/result structs shared by the ring cells, evaluator and top level.
`default_nettype none
package nsps_pkg;
	localparam int SCALE_DEPTH = 64;
	localparam int IDX_W       = $clog2(SCALE_DEPTH);
	localparam int FREQ_W      = 24;
	localparam int QFREQ_W     = 25;
	localparam int CNT_W       = 7;
	localparam int PROD_W      = 2 * FREQ_W;
	localparam int APB_AW      = 2;
	localparam int APB_DW      = 32;

	localparam logic [APB_AW-1:0] REG_SCALE_COUNT = APB_AW'(0);
	localparam logic              REQ_LOAD        = 1'b0;
	localparam logic              REQ_SNAP        = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic             start;
		logic             active;
		logic             in_use;
		logic [IDX_W-1:0] idx;
	} eval_ctl_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [FREQ_W-1:0] val;
	} best_t;
endpackage
`default_nettype wire

/* rtl/nsps_cell.sv */
// One cell of the scale table ring: holds a single entry, loads it directly
// or takes its neighbour's entry on a shift. Uses nsps_pkg.
`default_nettype none
module nsps_cell (
	input  wire logic                           clk,
	input  wire nsps_pkg::cell_ctl_t            ctl,
	input  wire logic [nsps_pkg::FREQ_W-1:0]    load_data,
	input  wire logic [nsps_pkg::FREQ_W-1:0]    nbr_data,
	output logic      [nsps_pkg::FREQ_W-1:0]    entry
);
	logic [nsps_pkg::FREQ_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= nbr_data;
		end else if (ctl.load) begin
			entry_q <= load_data;
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

/* rtl/nsps_eval.sv */
// Best-entry evaluator at the head of the ring: orders each entry against the
// query, then keeps the nearest by cross-multiplied ratios. Uses nsps_pkg.
`default_nettype none
module nsps_eval (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire nsps_pkg::eval_ctl_t            ctl,
	input  wire logic [nsps_pkg::FREQ_W-1:0]    entry,
	input  wire logic [nsps_pkg::FREQ_W-1:0]    query,
	output nsps_pkg::best_t                     best
);
	logic                          vld_s1;
	logic [nsps_pkg::IDX_W-1:0]    idx_s1;
	logic [nsps_pkg::FREQ_W-1:0]   val_s1;
	logic [nsps_pkg::FREQ_W-1:0]   hi_s1;
	logic [nsps_pkg::FREQ_W-1:0]   lo_s1;

	logic                          found_q;
	logic [nsps_pkg::IDX_W-1:0]    idx_q;
	logic [nsps_pkg::FREQ_W-1:0]   val_q;
	logic [nsps_pkg::FREQ_W-1:0]   hi_q;
	logic [nsps_pkg::FREQ_W-1:0]   lo_q;

	logic                          ent_gt;
	logic [nsps_pkg::PROD_W-1:0]   cand_prod;
	logic [nsps_pkg::PROD_W-1:0]   best_prod;
	logic                          better;

	assign ent_gt = entry > query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.active && ctl.in_use && (entry != '0);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ctl.idx;
		val_s1 <= entry;
		hi_s1  <= ent_gt ? entry : query;
		lo_s1  <= ent_gt ? query : entry;
	end

	// a nearer than b when hi_a * lo_b < hi_b * lo_a
	assign cand_prod = nsps_pkg::PROD_W'(hi_s1) * nsps_pkg::PROD_W'(lo_q);
	assign best_prod = nsps_pkg::PROD_W'(hi_q) * nsps_pkg::PROD_W'(lo_s1);
	assign better    = !found_q || (cand_prod < best_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (vld_s1 && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && better && !ctl.start) begin
			idx_q <= idx_s1;
			val_q <= val_s1;
			hi_q  <= hi_s1;
			lo_q  <= lo_s1;
		end
	end

	assign best.found = found_q;
	assign best.idx   = idx_q;
	assign best.val   = val_q;
endmodule
`default_nettype wire

/* rtl/nearest_scale_pitch_snap_core.sv */
// Nearest-scale pitch snap: top level with handshakes, APB register, the
// scale table ring of nsps_cell and the nsps_eval unit. Uses nsps_pkg and
// nearest_scale_pitch_snap_core_defines.svh.
//
// Usage:
//   Input items arrive on s_t*. tuser = 0 loads entry_index with entry_freq
//   and gives no result; tuser = 1 snaps query_freq and gives one result
//   item on m_t*, with tlast copied from the query.
//   scale_count is written over APB at address 0; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   A positive query rotates the 64-entry ring once past the evaluator, one
//   entry per cycle, then drains the compare stage in the flush state and
//   loads the result register in the done state once the output register
//   is free; only then is a new item taken. A non-positive query goes
//   straight from idle to the done state; a load item leaves the block idle.
//   Results sit in an output register; the next item is accepted while one
//   waits, but a finished result is held back until m_tready frees it.
//   Reset clears the count and control; table contents are undefined until
//   loaded.
`default_nettype none
`include "nearest_scale_pitch_snap_core_defines.svh"
module nearest_scale_pitch_snap_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [5:0] entry_index, [29:6] entry_freq, [54:30] query_freq, [55] zero
	input  wire logic [55:0]                     s_tdata,
	// [0] req_type
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [24:0] snapped_freq, [30:25] snap_index, [31] zero
	output logic [31:0]                          m_tdata,
	// [0] passed_through
	output logic                                 m_tuser,
	output logic                                 m_tlast,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [nsps_pkg::APB_AW-1:0]     paddr,
	input  wire logic [nsps_pkg::APB_DW-1:0]     pwdata,
	output logic      [nsps_pkg::APB_DW-1:0]     prdata,
	output logic                                 pready
);
	localparam int D = nsps_pkg::SCALE_DEPTH;

	nsps_pkg::state_t                     state_q, state_nx;
	logic [nsps_pkg::IDX_W-1:0]           step_q;
	logic [nsps_pkg::CNT_W-1:0]           count_q;
	logic [nsps_pkg::QFREQ_W-1:0]         query_q;
	logic                                 last_q;
	logic                                 unv_q;
	logic                                 m_valid_q;
	logic [nsps_pkg::QFREQ_W-1:0]         m_freq_q;
	logic [nsps_pkg::IDX_W-1:0]           m_idx_q;
	logic                                 m_pt_q;
	logic                                 m_last_q;

	logic [nsps_pkg::IDX_W-1:0]           in_idx;
	logic [nsps_pkg::FREQ_W-1:0]          in_efreq;
	logic [nsps_pkg::QFREQ_W-1:0]         in_qfreq;
	logic                                 in_acc;
	logic                                 in_pos;
	logic                                 out_free;
	logic                                 res_load;
	logic                                 shift;
	logic                                 load_item;
	logic                                 snap_item;
	logic [nsps_pkg::FREQ_W-1:0]          entries [D];
	nsps_pkg::eval_ctl_t                  ev_ctl;
	nsps_pkg::best_t                      best;
	logic                                 last_step;

	assign in_idx   = s_tdata[5:0];
	assign in_efreq = s_tdata[29:6];
	assign in_qfreq = s_tdata[54:30];
	assign in_pos   = !in_qfreq[nsps_pkg::QFREQ_W-1] && (in_qfreq != '0);
	assign in_acc   = s_tvalid && s_tready;
	assign load_item = in_acc && (s_tuser == nsps_pkg::REQ_LOAD);
	assign snap_item = in_acc && (s_tuser == nsps_pkg::REQ_SNAP);
	assign out_free  = !m_valid_q || m_tready;
	assign last_step = (step_q == nsps_pkg::IDX_W'(D - 1));

	// APB
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr == nsps_pkg::REG_SCALE_COUNT) begin
			prdata = nsps_pkg::APB_DW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr == nsps_pkg::REG_SCALE_COUNT) begin
			count_q <= pwdata[nsps_pkg::CNT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nsps_pkg::ST_IDLE: begin
				if (snap_item) begin
					state_nx = in_pos ? nsps_pkg::ST_RUN : nsps_pkg::ST_DONE;
				end
			end
			nsps_pkg::ST_RUN: begin
				if (last_step) begin
					state_nx = nsps_pkg::ST_FLUSH;
				end
			end
			nsps_pkg::ST_FLUSH: state_nx = nsps_pkg::ST_DONE;
			nsps_pkg::ST_DONE: begin
				if (out_free) begin
					state_nx = nsps_pkg::ST_IDLE;
				end
			end
			default: state_nx = nsps_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		shift    = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			nsps_pkg::ST_IDLE:  s_tready = 1'b1;
			nsps_pkg::ST_RUN:   shift    = 1'b1;
			nsps_pkg::ST_FLUSH: ;
			nsps_pkg::ST_DONE:  res_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsps_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (shift) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_item) begin
			query_q <= in_qfreq;
			last_q  <= s_tlast;
			unv_q   <= !in_pos;
		end
	end

	// scale table ring: entry j reaches cell 0 at step j
	for (genvar i = 0; i < D; i++) begin : g_cell
		nsps_pkg::cell_ctl_t cctl;
		assign cctl.shift = shift;
		assign cctl.load  = load_item && (in_idx == nsps_pkg::IDX_W'(i));
		nsps_cell u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.load_data (in_efreq),
			.nbr_data  (entries[(i + 1) % D]),
			.entry     (entries[i])
		);
	end

	assign ev_ctl.start  = snap_item;
	assign ev_ctl.active = shift;
	assign ev_ctl.in_use = {1'b0, step_q} < count_q;
	assign ev_ctl.idx    = step_q;

	nsps_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ev_ctl),
		.entry  (entries[0]),
		.query  (query_q[nsps_pkg::FREQ_W-1:0]),
		.best   (best)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_last_q <= last_q;
			if (unv_q) begin
				m_freq_q <= query_q;
				m_idx_q  <= '0;
				m_pt_q   <= 1'b1;
			end else if (best.found) begin
				m_freq_q <= nsps_pkg::QFREQ_W'(best.val);
				m_idx_q  <= best.idx;
				m_pt_q   <= 1'b0;
			end else begin
				m_freq_q <= '0;
				m_idx_q  <= '0;
				m_pt_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_idx_q, m_freq_q};
	assign m_tuser  = m_pt_q;
	assign m_tlast  = m_last_q;

	`NSPS_ASSERT_IMPL(a_ring_home, state_q != nsps_pkg::ST_RUN, step_q == '0, "ring not home")
	`NSPS_ASSERT_NEXT(a_flush_done, state_q == nsps_pkg::ST_FLUSH, state_q == nsps_pkg::ST_DONE, "no done")
	`NSPS_ASSERT_IMPL(a_pt_index, m_tvalid && m_tuser, m_tdata[30:25] == '0, "pass-through index")
	`NSPS_ASSERT_IMPL(a_chosen_nonzero, m_tvalid && !m_tuser, m_tdata[24:0] != '0, "zero entry chosen")
endmodule
`default_nettype wire
